[sv/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while in reset.
`define AWB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define AWB_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

[sv/gwawb_pkg.sv]
package gwawb_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_NORM,
        ST_WAIT
    } state_t;

    // input opcodes
    localparam logic OP_FRAME_END = 1'b0;
    localparam logic OP_START     = 1'b1;

    // register indexes (paddr[2])
    localparam logic REG_TARGET_PIPE     = 1'b0;
    localparam logic REG_UPDATE_INTERVAL = 1'b1;

    localparam logic [1:0]  TARGET_PIPE_RST = 2'd1;
    localparam logic [15:0] INTERVAL_RST    = 16'd1;

    // gain coding
    localparam int          FRAC_BITS    = 8;      // 128 scale plus one rounding bit
    localparam logic [7:0]  QS_LIMIT     = 8'd254; // 2 * 127
    localparam logic [7:0]  QS_ALL_ONES  = 8'hFF;
    localparam logic [7:0]  MULT_SAT_THR = 8'd253;
    localparam logic [6:0]  MULT_MAX     = 7'd127;
    localparam logic [2:0]  SHIFT_MAX    = 3'd7;
    localparam logic [2:0]  UNITY_SHIFT  = 3'd1;
    localparam logic [6:0]  UNITY_MULT   = 7'd64;

endpackage

[sv/gray_world_awb_gain_calc.sv]
// Gray-world white balance gain calculator. Each input word is a frame-end
// event (opcode 0) or a start event (opcode 1, clears the frame counter).
// Frame ends from pipes other than target_pipe are dropped. Counted frame
// ends advance a 16-bit frame counter; when it reaches update_interval the
// counter clears and, if the red, green and blue sums are all nonzero, one
// result word is produced with red and blue gains (green/2)/red and
// (green/2)/blue coded as shift (0..7) and multiplier (0..127), where
// gain ~= mult * 2^shift / 128; green always reads shift 1, mult 64.
// Only the low STAT_WIDTH bits of each sum are used. Words that do not
// trigger an update leave the input side ready. An update runs both gains
// through one shared restoring divider that retires one quotient bit per
// cycle, followed by a shift search that tests one shift per cycle, from
// shift 0 up to 7 at most, for each gain. The input side is ready again
// once the result sits in the output register; a finished result waits
// there for m_ready.
`include "assert_macros.svh"

module gray_world_awb_gain_calc #(
    parameter int STAT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [1:0]  s_pipe_id,
    input  logic [31:0] s_sum_red,
    input  logic [31:0] s_sum_green,
    input  logic [31:0] s_sum_blue,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_red_shift,
    output logic [6:0]  m_red_mult,
    output logic [2:0]  m_green_shift,
    output logic [6:0]  m_green_mult,
    output logic [2:0]  m_blue_shift,
    output logic [6:0]  m_blue_mult,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int W  = STAT_WIDTH;
    localparam int FB = gwawb_pkg::FRAC_BITS;
    localparam int QW = W + FB - 1;        // numerator (g>>1)<<8 width
    localparam int CW = $clog2(QW);

    gwawb_pkg::state_t state_reg, state_next;

    // config
    logic [1:0]    target_pipe_reg;
    logic [15:0]   interval_reg;
    logic [15:0]   fc_reg, fc_next;

    // datapath
    logic [W-2:0]  num_reg,  num_next;    // green >> 1
    logic [W-1:0]  den_reg,  den_next;    // current divisor
    logic [W-1:0]  blue_reg, blue_next;
    logic [QW-1:0] nq_reg,   nq_next;     // numerator out / quotient in
    logic [W-1:0]  rem_reg,  rem_next;
    logic [CW-1:0] bit_cnt_reg, bit_cnt_next;
    logic [2:0]    step_reg, step_next;
    logic          sticky_reg, sticky_next;
    logic          gain_sel_reg, gain_sel_next;   // 0 red, 1 blue
    logic [2:0]    red_shift_reg, red_shift_next;
    logic [6:0]    red_mult_reg,  red_mult_next;
    logic [2:0]    blue_shift_reg, blue_shift_next;
    logic [6:0]    blue_mult_reg,  blue_mult_next;

    // output register
    logic          m_valid_reg, m_valid_next;
    logic [2:0]    o_red_shift_reg,  o_red_shift_next;
    logic [6:0]    o_red_mult_reg,   o_red_mult_next;
    logic [2:0]    o_blue_shift_reg, o_blue_shift_next;
    logic [6:0]    o_blue_mult_reg,  o_blue_mult_next;

    logic          accept;
    logic          go;
    logic          div_last;
    logic          norm_done;
    logic          slot_free;
    logic [W-1:0]  r_in, g_in, b_in;
    logic [15:0]   fc_inc;

    // divider step
    logic [W:0]    rem_sh;
    logic [W:0]    diff;
    logic          qbit;

    // shift search
    logic          hi_zero;
    logic [7:0]    lo;
    logic          sticky_eff;
    logic          fits;
    logic          sat;
    logic [8:0]    lo_inc;
    logic [6:0]    mult_cur;

    assign pready  = 1'b1;
    assign s_ready = (state_reg == gwawb_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign r_in = s_sum_red[W-1:0];
    assign g_in = s_sum_green[W-1:0];
    assign b_in = s_sum_blue[W-1:0];
    assign fc_inc = fc_reg + 16'd1;

    // update due with usable sums
    assign go = accept && (s_opcode == gwawb_pkg::OP_FRAME_END)
             && (s_pipe_id == target_pipe_reg) && !(fc_inc < interval_reg)
             && (r_in != '0) && (g_in != '0) && (b_in != '0);

    assign div_last  = (bit_cnt_reg == CW'(QW - 1));
    assign slot_free = !m_valid_reg || m_ready;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {rem_reg, nq_reg[QW-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign qbit   = !diff[W];

    // nq holds Q >> s; x = Q/2^(s+1) must not exceed 127
    assign hi_zero    = ~|nq_reg[QW-1:8];
    assign lo         = nq_reg[7:0];
    assign sticky_eff = sticky_reg || (rem_reg != '0);
    assign fits       = hi_zero && (lo != gwawb_pkg::QS_ALL_ONES)
                     && !((lo == gwawb_pkg::QS_LIMIT) && sticky_eff);
    assign norm_done  = fits || (step_reg == gwawb_pkg::SHIFT_MAX);
    assign sat        = !hi_zero || (lo >= gwawb_pkg::MULT_SAT_THR);
    assign lo_inc     = {1'b0, lo} + 9'd1;
    assign mult_cur   = sat ? gwawb_pkg::MULT_MAX : lo_inc[7:1];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gwawb_pkg::ST_IDLE: begin
                if (go) state_next = gwawb_pkg::ST_DIV;
            end
            gwawb_pkg::ST_DIV: begin
                if (div_last) state_next = gwawb_pkg::ST_NORM;
            end
            gwawb_pkg::ST_NORM: begin
                if (norm_done) begin
                    state_next = gain_sel_reg ? gwawb_pkg::ST_WAIT : gwawb_pkg::ST_DIV;
                end
            end
            gwawb_pkg::ST_WAIT: begin
                if (slot_free) state_next = gwawb_pkg::ST_IDLE;
            end
            default: state_next = gwawb_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        fc_next           = fc_reg;
        num_next          = num_reg;
        den_next          = den_reg;
        blue_next         = blue_reg;
        nq_next           = nq_reg;
        rem_next          = rem_reg;
        bit_cnt_next      = bit_cnt_reg;
        step_next         = step_reg;
        sticky_next       = sticky_reg;
        gain_sel_next     = gain_sel_reg;
        red_shift_next    = red_shift_reg;
        red_mult_next     = red_mult_reg;
        blue_shift_next   = blue_shift_reg;
        blue_mult_next    = blue_mult_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        o_red_shift_next  = o_red_shift_reg;
        o_red_mult_next   = o_red_mult_reg;
        o_blue_shift_next = o_blue_shift_reg;
        o_blue_mult_next  = o_blue_mult_reg;

        unique case (state_reg)
            gwawb_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_opcode == gwawb_pkg::OP_START) begin
                        fc_next = '0;
                    end else if (s_pipe_id == target_pipe_reg) begin
                        fc_next = (fc_inc < interval_reg) ? fc_inc : 16'd0;
                    end
                end
                if (go) begin
                    num_next      = g_in[W-1:1];
                    den_next      = r_in;
                    blue_next     = b_in;
                    nq_next       = {g_in[W-1:1], {FB{1'b0}}};
                    rem_next      = '0;
                    bit_cnt_next  = '0;
                    step_next     = '0;
                    sticky_next   = 1'b0;
                    gain_sel_next = 1'b0;
                end
            end
            gwawb_pkg::ST_DIV: begin
                rem_next     = qbit ? diff[W-1:0] : rem_sh[W-1:0];
                nq_next      = {nq_reg[QW-2:0], qbit};
                bit_cnt_next = bit_cnt_reg + CW'(1);
            end
            gwawb_pkg::ST_NORM: begin
                if (norm_done) begin
                    if (!gain_sel_reg) begin
                        red_shift_next = step_reg;
                        red_mult_next  = mult_cur;
                        // reload the divider for blue
                        den_next       = blue_reg;
                        nq_next        = {num_reg, {FB{1'b0}}};
                        rem_next       = '0;
                        bit_cnt_next   = '0;
                        step_next      = '0;
                        sticky_next    = 1'b0;
                        gain_sel_next  = 1'b1;
                    end else begin
                        blue_shift_next = step_reg;
                        blue_mult_next  = mult_cur;
                    end
                end else begin
                    nq_next     = {1'b0, nq_reg[QW-1:1]};
                    sticky_next = sticky_reg || nq_reg[0];
                    step_next   = step_reg + 3'd1;
                end
            end
            gwawb_pkg::ST_WAIT: begin
                if (slot_free) begin
                    m_valid_next      = 1'b1;
                    o_red_shift_next  = red_shift_reg;
                    o_red_mult_next   = red_mult_reg;
                    o_blue_shift_next = blue_shift_reg;
                    o_blue_mult_next  = blue_mult_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= gwawb_pkg::ST_IDLE;
            fc_reg          <= '0;
            m_valid_reg     <= 1'b0;
            target_pipe_reg <= gwawb_pkg::TARGET_PIPE_RST;
            interval_reg    <= gwawb_pkg::INTERVAL_RST;
        end else begin
            state_reg   <= state_next;
            fc_reg      <= fc_next;
            m_valid_reg <= m_valid_next;
            if (psel && penable && pwrite && pready) begin
                unique case (paddr[2])
                    gwawb_pkg::REG_TARGET_PIPE:     target_pipe_reg <= pwdata[1:0];
                    gwawb_pkg::REG_UPDATE_INTERVAL: interval_reg    <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        num_reg          <= num_next;
        den_reg          <= den_next;
        blue_reg         <= blue_next;
        nq_reg           <= nq_next;
        rem_reg          <= rem_next;
        bit_cnt_reg      <= bit_cnt_next;
        step_reg         <= step_next;
        sticky_reg       <= sticky_next;
        gain_sel_reg     <= gain_sel_next;
        red_shift_reg    <= red_shift_next;
        red_mult_reg     <= red_mult_next;
        blue_shift_reg   <= blue_shift_next;
        blue_mult_reg    <= blue_mult_next;
        o_red_shift_reg  <= o_red_shift_next;
        o_red_mult_reg   <= o_red_mult_next;
        o_blue_shift_reg <= o_blue_shift_next;
        o_blue_mult_reg  <= o_blue_mult_next;
    end

    // register readback
    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            gwawb_pkg::REG_TARGET_PIPE:     prdata = {30'd0, target_pipe_reg};
            gwawb_pkg::REG_UPDATE_INTERVAL: prdata = {16'd0, interval_reg};
            default: prdata = '0;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_red_shift   = o_red_shift_reg;
    assign m_red_mult    = o_red_mult_reg;
    assign m_green_shift = gwawb_pkg::UNITY_SHIFT;
    assign m_green_mult  = gwawb_pkg::UNITY_MULT;
    assign m_blue_shift  = o_blue_shift_reg;
    assign m_blue_mult   = o_blue_mult_reg;

    // partial remainder stays below the divisor while a gain is in work
    `AWB_NEVER(a_rem_below_den, ((state_reg == gwawb_pkg::ST_DIV) || (state_reg == gwawb_pkg::ST_NORM)) && !(rem_reg < den_reg), "remainder not below divisor")
    // a new result word is loaded only out of the wait state
    `AWB_ASSERT(a_out_from_wait, $rose(m_valid_reg) |-> ($past(state_reg) == gwawb_pkg::ST_WAIT), "result loaded outside wait state")
    // shift search ends by the largest shift
    `AWB_ASSERT(a_norm_bounded, ((state_reg == gwawb_pkg::ST_NORM) && (step_reg == gwawb_pkg::SHIFT_MAX)) |=> (state_reg != gwawb_pkg::ST_NORM) || (step_reg == 3'd0), "shift search overran")

endmodule
